// File: design/assert_macros.svh
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define RSH_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rsh assertion failed");

// next-cycle implication, off during reset
`define RSH_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rsh assertion failed");

// next-cycle implication, checked during reset as well
`define RSH_ASSERT_NXT_ALL(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("rsh assertion failed");

`endif

// File: design/rsh_pkg.sv
// package: widths and beat types of the ray/sphere hit test pipeline
`timescale 1ns / 1ps
`default_nettype none

package rsh_pkg;

    localparam int POS_W  = 32;              // positions, 1/64 m
    localparam int DIR_W  = 16;              // direction, Q1.15
    localparam int RAD_W  = 31;              // radius, unsigned
    localparam int OFF_W  = POS_W + 1;       // origin minus centre
    localparam int DSQ_W  = 2 * DIR_W - 1;   // one dir component squared
    localparam int DOF_W  = DIR_W + OFF_W;   // dir times offset
    localparam int OSQ_W  = 2 * POS_W;       // one offset component squared
    localparam int R2_W   = 2 * RAD_W;       // radius squared
    localparam int A_W    = DSQ_W + 1;       // |dir|^2
    localparam int BD_W   = DOF_W + 2;       // dir . offset
    localparam int SQ_W   = OSQ_W + 2;       // |offset|^2
    localparam int BM_W   = BD_W - 1;        // magnitude of a positive dir . offset
    localparam int BH_W   = BM_W / 2;        // half of that magnitude
    localparam int PP_W   = 2 * BH_W;        // half by half product
    localparam int CK_W   = SQ_W / 3;        // chunk of c for a * c
    localparam int PA_W   = A_W + CK_W;      // a times one chunk
    localparam int LR_W   = 2 * BM_W;        // both sides of the final compare

    // number of register stages from input beat to result beat
    localparam int RSH_DEPTH = 7;
    localparam int CNT_W     = $clog2(RSH_DEPTH + 1) + 1;

    typedef struct packed {
        logic signed [POS_W-1:0] ray_origin_x;
        logic signed [POS_W-1:0] ray_origin_y;
        logic signed [POS_W-1:0] ray_origin_z;
        logic signed [DIR_W-1:0] ray_dir_x;
        logic signed [DIR_W-1:0] ray_dir_y;
        logic signed [DIR_W-1:0] ray_dir_z;
        logic signed [POS_W-1:0] centre_x;
        logic signed [POS_W-1:0] centre_y;
        logic signed [POS_W-1:0] centre_z;
        logic        [RAD_W-1:0] sphere_radius;
    } t_ray_in;

    typedef struct packed {
        logic hit;
    } t_ray_out;

    typedef struct packed {
        logic signed [OFF_W-1:0] off_x;
        logic signed [OFF_W-1:0] off_y;
        logic signed [OFF_W-1:0] off_z;
        logic signed [DIR_W-1:0] dir_x;
        logic signed [DIR_W-1:0] dir_y;
        logic signed [DIR_W-1:0] dir_z;
        logic        [RAD_W-1:0] radius;
    } t_off_beat;

    typedef struct packed {
        logic        [A_W-1:0]  a;
        logic signed [BD_W-1:0] bd;
        logic        [SQ_W-1:0] sq;
        logic        [R2_W-1:0] r2;
    } t_sum_beat;

endpackage

`default_nettype wire

// File: design/rsh_stream_if.sv
// valid/ready stream interface carrying one payload beat
`timescale 1ns / 1ps
`default_nettype none

interface rsh_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: design/rsh_prep.sv
// first stage: offset from sphere centre to ray origin
`timescale 1ns / 1ps
`default_nettype none

module rsh_prep
    import rsh_pkg::*;
(
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_vld,
    output logic      o_rdy,
    input  t_ray_in   i_data,
    output logic      o_vld,
    input  wire       i_rdy,
    output t_off_beat o_data
);

    logic      r_vld;
    t_off_beat r_data;
    t_off_beat n_data;
    logic      w_en;

    // stage moves when empty or when downstream takes its beat
    assign w_en  = !r_vld || i_rdy;
    assign o_rdy = w_en;

    // widen to 33 bits before subtracting
    always_comb begin
        n_data.off_x  = OFF_W'(i_data.ray_origin_x) - OFF_W'(i_data.centre_x);
        n_data.off_y  = OFF_W'(i_data.ray_origin_y) - OFF_W'(i_data.centre_y);
        n_data.off_z  = OFF_W'(i_data.ray_origin_z) - OFF_W'(i_data.centre_z);
        n_data.dir_x  = i_data.ray_dir_x;
        n_data.dir_y  = i_data.ray_dir_y;
        n_data.dir_z  = i_data.ray_dir_z;
        n_data.radius = i_data.sphere_radius;
    end

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_en) begin
            r_vld <= i_vld;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_data <= n_data;
        end
    end

    assign o_vld  = r_vld;
    assign o_data = r_data;

endmodule

`default_nettype wire

// File: design/rsh_prod.sv
// stages two and three: component products, then the dot-product sums
`timescale 1ns / 1ps
`default_nettype none

module rsh_prod
    import rsh_pkg::*;
(
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_vld,
    output logic      o_rdy,
    input  t_off_beat i_data,
    output logic      o_vld,
    input  wire       i_rdy,
    output t_sum_beat o_data
);

    logic [1:0] r_vld;
    logic [1:0] w_en;

    logic signed [OFF_W-1:0]   w_off [3];
    logic signed [DIR_W-1:0]   w_dir [3];
    logic signed [2*DIR_W-1:0] w_dsq [3];
    logic signed [DOF_W-1:0]   w_dof [3];
    logic signed [2*OFF_W-1:0] w_osq [3];
    logic        [R2_W-1:0]    w_r2;

    logic        [DSQ_W-1:0] r_dsq [3];
    logic signed [DOF_W-1:0] r_dof [3];
    logic        [OSQ_W-1:0] r_osq [3];
    logic        [R2_W-1:0]  r_r2;

    t_sum_beat r_sum;
    t_sum_beat n_sum;

    // each stage moves when empty or when the one after it moves
    assign w_en[1] = !r_vld[1] || i_rdy;
    assign w_en[0] = !r_vld[0] || w_en[1];
    assign o_rdy   = w_en[0];

    assign w_off[0] = i_data.off_x;
    assign w_off[1] = i_data.off_y;
    assign w_off[2] = i_data.off_z;
    assign w_dir[0] = i_data.dir_x;
    assign w_dir[1] = i_data.dir_y;
    assign w_dir[2] = i_data.dir_z;

    // per-component products at full width
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_dsq[k] = w_dir[k] * w_dir[k];
            w_dof[k] = w_dir[k] * w_off[k];
            w_osq[k] = w_off[k] * w_off[k];
        end
    end
    assign w_r2 = i_data.radius * i_data.radius;

    // sums of the three components; squares are nonnegative
    always_comb begin
        n_sum.a  = A_W'(r_dsq[0]) + A_W'(r_dsq[1]) + A_W'(r_dsq[2]);
        n_sum.bd = BD_W'(r_dof[0]) + BD_W'(r_dof[1]) + BD_W'(r_dof[2]);
        n_sum.sq = SQ_W'(r_osq[0]) + SQ_W'(r_osq[1]) + SQ_W'(r_osq[2]);
        n_sum.r2 = r_r2;
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_vld;
            end
            if (w_en[1]) begin
                r_vld[1] <= r_vld[0];
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            for (int k = 0; k < 3; k++) begin
                r_dsq[k] <= w_dsq[k][DSQ_W-1:0];
                r_dof[k] <= w_dof[k];
                r_osq[k] <= w_osq[k][OSQ_W-1:0];
            end
            r_r2 <= w_r2;
        end
        if (w_en[1]) begin
            r_sum <= n_sum;
        end
    end

    assign o_vld  = r_vld[1];
    assign o_data = r_sum;

endmodule

`default_nettype wire

// File: design/rsh_disc.sv
// stages four to seven: c, split products for b^2 >= 4ac, final compare
`timescale 1ns / 1ps
`default_nettype none

module rsh_disc
    import rsh_pkg::*;
(
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_vld,
    output logic      o_rdy,
    input  t_sum_beat i_data,
    output logic      o_vld,
    input  wire       i_rdy,
    output logic      o_hit
);

    logic [3:0] r_vld;
    logic [3:0] w_en;

    // stage four: c and the early-out conditions
    logic [A_W-1:0]  r_a;
    logic [BM_W-1:0] r_bm;
    logic [SQ_W-1:0] r_c;
    logic            r_ok4;
    logic            n_ok4;
    logic [SQ_W-1:0] n_c;

    // stage five: partial products
    logic [PP_W-1:0] r_hh;
    logic [PP_W-1:0] r_hl;
    logic [PP_W-1:0] r_ll;
    logic [PA_W-1:0] r_p0;
    logic [PA_W-1:0] r_p1;
    logic [PA_W-1:0] r_p2;
    logic            r_ok5;
    logic [BH_W-1:0] w_bh;
    logic [BH_W-1:0] w_bl;

    // stage six: both sides assembled
    logic [LR_W-1:0] r_lhs;
    logic [LR_W-1:0] r_rhs;
    logic            r_ok6;
    logic [LR_W-1:0] n_lhs;
    logic [LR_W-1:0] n_rhs;

    // stage seven: result
    logic r_hit;

    // stall chain from the output back to the input
    always_comb begin
        w_en[3] = !r_vld[3] || i_rdy;
        for (int k = 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end
    assign o_rdy = w_en[0];

    // hit needs a nonzero, dir . offset positive and origin outside the sphere
    assign n_c   = i_data.sq - SQ_W'(i_data.r2);
    assign n_ok4 = (i_data.a != '0) && !i_data.bd[BD_W-1] && (i_data.bd != '0)
                   && (i_data.sq > SQ_W'(i_data.r2));

    // split the magnitude of dir . offset into halves
    assign w_bh = r_bm[BM_W-1:BH_W];
    assign w_bl = r_bm[BH_W-1:0];

    // (dir . offset)^2 and a * c from shifted partial products
    assign n_lhs = {r_hh, {PP_W{1'b0}}}
                 + {{(LR_W-PP_W-BH_W-1){1'b0}}, r_hl, {(BH_W+1){1'b0}}}
                 + {{(LR_W-PP_W){1'b0}}, r_ll};
    assign n_rhs = {{(LR_W-PA_W-2*CK_W){1'b0}}, r_p2, {(2*CK_W){1'b0}}}
                 + {{(LR_W-PA_W-CK_W){1'b0}}, r_p1, {CK_W{1'b0}}}
                 + {{(LR_W-PA_W){1'b0}}, r_p0};

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_vld;
            end
            for (int k = 1; k < 4; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_a   <= i_data.a;
            r_bm  <= i_data.bd[BM_W-1:0];
            r_c   <= n_c;
            r_ok4 <= n_ok4;
        end
        if (w_en[1]) begin
            r_hh  <= w_bh * w_bh;
            r_hl  <= w_bh * w_bl;
            r_ll  <= w_bl * w_bl;
            r_p0  <= r_a * r_c[CK_W-1:0];
            r_p1  <= r_a * r_c[2*CK_W-1:CK_W];
            r_p2  <= r_a * r_c[SQ_W-1:2*CK_W];
            r_ok5 <= r_ok4;
        end
        if (w_en[2]) begin
            r_lhs <= n_lhs;
            r_rhs <= n_rhs;
            r_ok6 <= r_ok5;
        end
        if (w_en[3]) begin
            r_hit <= r_ok6 && (r_lhs >= r_rhs);
        end
    end

    assign o_vld = r_vld[3];
    assign o_hit = r_hit;

endmodule

`default_nettype wire

// File: design/ray_sphere_hit_test_top.sv
// top level of the ray/sphere hit test pipeline
//
// i_in carries one ray/sphere pair per beat (origin, direction, centre,
// radius); o_out carries one hit bit per beat, in the order of the inputs.
// Both channels are valid/ready: a beat moves when valid and ready are high
// at a rising edge of i_clk.
// Each input beat passes through seven register stages to its result beat.
// Throughput is one beat per cycle while o_out is ready; each stage is one multiplier or one wide
// add/compare deep, so the stage count is set by the 50x50 square of
// dir . offset and the 32x66 product a * c, each done as partial products.
// Every stage has its own valid bit and moves when it is empty or the next
// stage moves, so bubbles close up and the block keeps taking beats while a
// result waits, until all seven stages are full.
// When the receiver stalls, o_out holds its beat; i_in.ready drops only once
// the whole pipeline is full.
// i_rst_n is synchronous and active low; it clears all valid bits, nothing
// is lost but the beats in flight.
`timescale 1ns / 1ps
`default_nettype none

module ray_sphere_hit_test_top
    import rsh_pkg::*;
(
    input  wire           i_clk,
    input  wire           i_rst_n,
    rsh_stream_if.sink    i_in,
    rsh_stream_if.source  o_out
);

    logic      w_off_vld;
    logic      w_off_rdy;
    t_off_beat w_off;
    logic      w_sum_vld;
    logic      w_sum_rdy;
    t_sum_beat w_sum;
    logic      w_hit;

    // offset stage
    rsh_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (i_in.valid),
        .o_rdy   (i_in.ready),
        .i_data  (i_in.data),
        .o_vld   (w_off_vld),
        .i_rdy   (w_off_rdy),
        .o_data  (w_off)
    );

    // products and sums
    rsh_prod u_prod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_off_vld),
        .o_rdy   (w_off_rdy),
        .i_data  (w_off),
        .o_vld   (w_sum_vld),
        .i_rdy   (w_sum_rdy),
        .o_data  (w_sum)
    );

    // discriminant test
    rsh_disc u_disc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_sum_vld),
        .o_rdy   (w_sum_rdy),
        .i_data  (w_sum),
        .o_vld   (o_out.valid),
        .i_rdy   (o_out.ready),
        .o_hit   (w_hit)
    );

    assign o_out.data.hit = w_hit;

endmodule

`default_nettype wire

// File: design/rsh_checker.sv
// port-level checker for the hit test top, with its bind
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module rsh_checker
    import rsh_pkg::*;
(
    input wire i_clk,
    input wire i_rst_n,
    input wire i_in_valid,
    input wire i_in_ready,
    input wire i_out_valid,
    input wire i_out_ready,
    input wire i_out_hit
);

    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             w_in_beat;
    logic             w_out_beat;

    assign w_in_beat  = i_in_valid && i_in_ready;
    assign w_out_beat = i_out_valid && i_out_ready;

    // beats in flight
    always_comb begin
        n_cnt = r_cnt;
        if (w_in_beat && !w_out_beat) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!w_in_beat && w_out_beat) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // a stalled result beat stays and keeps its value
    `RSH_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    `RSH_ASSERT_NXT(a_hit_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_out_hit))

    // reset empties the pipeline
    `RSH_ASSERT_NXT_ALL(a_rst_empty, i_clk, !i_rst_n, !i_out_valid)

    // never more beats inside than stages, and no result without an input
    `RSH_ASSERT_IMP(a_cap, i_clk, i_rst_n, 1'b1, r_cnt <= CNT_W'(RSH_DEPTH))
    `RSH_ASSERT_IMP(a_no_phantom, i_clk, i_rst_n, i_out_valid, r_cnt != '0)

endmodule

bind ray_sphere_hit_test_top rsh_checker u_rsh_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_hit   (o_out.data.hit)
);

`default_nettype wire

// File: verif/rsh_hit_monitor.sv
// checker: predicts the hit bit of every accepted ray beat and compares results in order
`timescale 1ns / 1ps

module rsh_hit_monitor
    import rsh_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    rsh_stream_if i_in,
    rsh_stream_if i_out,
    output int    o_errors,
    output int    o_pending
);

    // wide enough for (dir . offset)^2 and a * c without any overflow
    localparam int WIDE_W     = 140;
    localparam int REPORT_MAX = 10;

    logic expected_hits[$];

    // exact hit test: ray leaves the sphere behind it
    function automatic logic predict_hit(input t_ray_in beat);
        logic signed [WIDE_W-1:0] ox, oy, oz, dx, dy, dz, rad, a, bd, c;
        ox  = $signed(beat.ray_origin_x) - $signed(beat.centre_x);
        oy  = $signed(beat.ray_origin_y) - $signed(beat.centre_y);
        oz  = $signed(beat.ray_origin_z) - $signed(beat.centre_z);
        dx  = $signed(beat.ray_dir_x);
        dy  = $signed(beat.ray_dir_y);
        dz  = $signed(beat.ray_dir_z);
        rad = beat.sphere_radius;
        a   = dx * dx + dy * dy + dz * dz;
        bd  = dx * ox + dy * oy + dz * oz;
        c   = ox * ox + oy * oy + oz * oz - rad * rad;
        // with a > 0, t < 0 iff b > 0, c > 0 and b^2 >= 4ac
        return (a != 0) && (bd > 0) && (c > 0) && (bd * bd >= a * c);
    endfunction

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    // queue a prediction per input beat, compare each result beat against the oldest
    always @(posedge i_clk) begin
        logic want;
        if (i_rst_n) begin
            if (i_in.valid && i_in.ready)
                expected_hits.insert(expected_hits.size(), predict_hit(i_in.data));
            if (i_out.valid && i_out.ready) begin
                if (expected_hits.size() == 0) begin
                    if (o_errors < REPORT_MAX)
                        $display("%0t: result beat hit=%0b with no prediction waiting",
                                 $time, i_out.data.hit);
                    o_errors = o_errors + 1;
                end else begin
                    want = expected_hits.pop_front();
                    if (i_out.data.hit !== want) begin
                        if (o_errors < REPORT_MAX)
                            $display("%0t: hit mismatch, expected %0b, got %0b",
                                     $time, want, i_out.data.hit);
                        o_errors = o_errors + 1;
                    end
                end
            end
            o_pending = expected_hits.size();
        end
    end

endmodule

// File: verif/tb_ray_sphere_hit_test_top.sv
// testbench top: clock, reset, ray stimulus, result-side stalls and the verdict
`timescale 1ns / 1ps

module tb_ray_sphere_hit_test_top;
    import rsh_pkg::*;

    localparam int RAY_COUNT   = 850;
    localparam int CYCLE_LIMIT = 200000;
    localparam int POS_MAX     = 32'sh7fffffff;
    localparam int POS_MIN     = 32'sh80000000;
    localparam int RAD_MAX     = 32'h7fffffff;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic steady;
    int   errors;
    int   pending;
    int   cycle_count;

    rsh_stream_if #(.T(t_ray_in))  ray_bus ();
    rsh_stream_if #(.T(t_ray_out)) hit_bus ();

    ray_sphere_hit_test_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (ray_bus),
        .o_out   (hit_bus)
    );

    rsh_hit_monitor hit_monitor (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (ray_bus),
        .i_out     (hit_bus),
        .o_errors  (errors),
        .o_pending (pending)
    );

    always #2 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // result side stalls about a quarter of the time, never during the steady stretch
    always @(negedge i_clk) begin
        hit_bus.ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 25);
    end

    function automatic t_ray_in make_ray(input int ox, input int oy, input int oz,
                                         input int dx, input int dy, input int dz,
                                         input int cx, input int cy, input int cz,
                                         input int rad);
        t_ray_in beat;
        beat.ray_origin_x  = ox;
        beat.ray_origin_y  = oy;
        beat.ray_origin_z  = oz;
        beat.ray_dir_x     = dx[DIR_W-1:0];
        beat.ray_dir_y     = dy[DIR_W-1:0];
        beat.ray_dir_z     = dz[DIR_W-1:0];
        beat.centre_x      = cx;
        beat.centre_y      = cy;
        beat.centre_z      = cz;
        beat.sphere_radius = rad[RAD_W-1:0];
        return beat;
    endfunction

    // random direction component, sometimes shrunk toward zero
    function automatic int rand_dir();
        logic signed [DIR_W-1:0] d16;
        int v;
        d16 = DIR_W'($urandom);
        v   = int'(d16);
        if ($urandom_range(0, 2) == 0)
            v = v >>> $urandom_range(0, 14);
        return v;
    endfunction

    function automatic int rand_span(input int k);
        return int'($urandom_range(0, 2 << k)) - (1 << k);
    endfunction

    function automatic int flip_dir(input int d);
        return (d == -32768) ? 32767 : -d;
    endfunction

    // ray mostly pointing away from the sphere, radius near the grazing distance
    function automatic t_ray_in aimed_ray();
        int     k, ox, oy, oz, cx, cy, cz, dx, dy, dz;
        real    ar, bdr, on2, rr;
        longint rl;
        k  = $urandom_range(2, 29);
        ox = rand_span(k);
        oy = rand_span(k);
        oz = rand_span(k);
        cx = int'($urandom) >>> 1;
        cy = int'($urandom) >>> 1;
        cz = int'($urandom) >>> 1;
        dx = rand_dir();
        dy = rand_dir();
        dz = rand_dir();
        bdr = real'(dx) * ox + real'(dy) * oy + real'(dz) * oz;
        if (bdr < 0.0 && $urandom_range(0, 4) != 0) begin
            dx  = flip_dir(dx);
            dy  = flip_dir(dy);
            dz  = flip_dir(dz);
            bdr = real'(dx) * ox + real'(dy) * oy + real'(dz) * oz;
        end
        ar  = real'(dx) * dx + real'(dy) * dy + real'(dz) * dz;
        on2 = real'(ox) * ox + real'(oy) * oy + real'(oz) * oz;
        if (ar == 0.0) begin
            rl = $urandom_range(0, RAD_MAX);
        end else begin
            rr = on2 - bdr * bdr / ar;
            if (rr < 0.0)
                rr = 0.0;
            rl = longint'($sqrt(rr)) + $urandom_range(0, 8) - 4;
        end
        if (rl < 0)
            rl = 0;
        if (rl > RAD_MAX)
            rl = RAD_MAX;
        return make_ray(cx + ox, cy + oy, cz + oz, dx, dy, dz, cx, cy, cz, int'(rl));
    endfunction

    // every field drawn over its whole range
    function automatic t_ray_in noise_ray();
        return make_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom, $urandom, $urandom);
    endfunction

    // small scene, random geometry
    function automatic t_ray_in near_ray();
        return make_ray(rand_span(11), rand_span(11), rand_span(11),
                        rand_dir(), rand_dir(), rand_dir(),
                        rand_span(11), rand_span(11), rand_span(11),
                        $urandom_range(0, 3000));
    endfunction

    // offer one beat, with random idle cycles ahead of it
    task automatic send_ray(input t_ray_in beat);
        while (!steady && $urandom_range(0, 99) < 25) begin
            ray_bus.valid <= 1'b0;
            @(negedge i_clk);
        end
        ray_bus.valid <= 1'b1;
        ray_bus.data  <= beat;
        @(posedge i_clk);
        while (!ray_bus.ready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // hold off input until every predicted result has come out
    task automatic wait_idle();
        ray_bus.valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0)
            @(negedge i_clk);
    endtask

    initial begin
        int pick;
        cycle_count   = 0;
        steady        = 1'b0;
        i_rst_n       = 1'b0;
        ray_bus.valid = 1'b0;
        ray_bus.data  = '0;
        hit_bus.ready = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: zero direction
        send_ray(make_ray(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_ray(make_ray(5000, 0, 0, 0, 0, 0, 0, 0, 0, 100));
        // plain hit, and the same ray turned toward the sphere
        send_ray(make_ray(1000, 0, 0, 16384, 0, 0, 0, 0, 0, 100));
        send_ray(make_ray(1000, 0, 0, -16384, 0, 0, 0, 0, 0, 100));
        // grazing ray: discriminant exactly zero, then just outside and just inside
        send_ray(make_ray(1000, 100, 0, 16384, 0, 0, 0, 0, 0, 100));
        send_ray(make_ray(1000, 100, 0, 16384, 0, 0, 0, 0, 0, 99));
        send_ray(make_ray(1000, 100, 0, 16384, 0, 0, 0, 0, 0, 101));
        // origin inside the sphere and exactly on it
        send_ray(make_ray(50, 0, 0, 16384, 0, 0, 0, 0, 0, 100));
        send_ray(make_ray(100, 0, 0, 16384, 0, 0, 0, 0, 0, 100));
        // field extremes, ray through the centre
        send_ray(make_ray(POS_MAX, POS_MAX, POS_MAX, 32767, 32767, 32767,
                          POS_MIN, POS_MIN, POS_MIN, 0));
        send_ray(make_ray(POS_MIN, POS_MIN, POS_MIN, -32768, -32768, -32768,
                          POS_MAX, POS_MAX, POS_MAX, RAD_MAX));
        send_ray(make_ray(POS_MAX, POS_MIN, 0, 32767, -32768, 0, 0, 0, 0, RAD_MAX));
        send_ray(make_ray(POS_MAX, 0, 0, -32768, 0, 0, POS_MAX, 0, 0, RAD_MAX));
        send_ray(make_ray(POS_MIN, POS_MAX, POS_MIN, 32767, -32768, 32767,
                          POS_MAX, POS_MIN, POS_MAX, RAD_MAX));
        send_ray(make_ray(-5000, 0, 0, -32768, 0, 0, 0, 0, 0, 10));
        // direction perpendicular to the offset
        send_ray(make_ray(1000, 0, 0, 0, 16384, 0, 0, 0, 0, 100));
        // other axes
        send_ray(make_ray(0, 2000, 0, 0, 23170, 0, 0, 0, 0, 500));
        send_ray(make_ray(0, 0, -2000, 0, 0, -23170, 0, 0, 0, 500));
        // smallest nonzero direction and radius zero
        send_ray(make_ray(1, 0, 0, 1, 0, 0, 0, 0, 0, 0));
        send_ray(make_ray(2, -1, 0, 1, 1, 1, 0, 0, 0, 0));
        send_ray(make_ray(10, 20, 30, 1, 2, 3, 0, 0, 0, 0));
        wait_idle();

        // random: mostly aimed rays, with small scenes and pure noise mixed in
        for (int n = 0; n < RAY_COUNT; n++) begin
            steady = (n >= 500 && n < 650);
            if (n == 425)
                wait_idle();
            pick = $urandom_range(0, 99);
            if (pick < 60)
                send_ray(aimed_ray());
            else if (pick < 80)
                send_ray(noise_ray());
            else
                send_ray(near_ray());
        end
        steady = 1'b0;

        // drain, then wait out any stray beat before the verdict
        wait_idle();
        repeat (4 * RSH_DEPTH) @(negedge i_clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
